### rtl/core/timestamped_ring_with_window_query_macros.svh
// Assertion macros shared by the checker of the timestamped ring.
`ifndef TIMESTAMPED_RING_WITH_WINDOW_QUERY_MACROS_SVH
`define TIMESTAMPED_RING_WITH_WINDOW_QUERY_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TRWQ_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TRWQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/trwq_pkg.sv
package trwq_pkg;

	localparam int OP_W      = 2;
	localparam int PAYLOAD_W = 32;
	localparam int TIME_W    = 63;
	localparam int BOUND_W   = 64;
	localparam int COUNT_W   = 7;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_QUERY  = 2'd1,
		OP_LATEST = 2'd2
	} op_t;

	typedef struct packed {
		logic accept_add;
		logic start_scan;
		logic start_latest;
		logic capture;
		logic advance;
		logic push_pend;
		logic push_last;
		logic push_marker;
	} ctrl_cmd_t;

	typedef struct packed {
		logic held_zero;
		logic scan_match;
		logic scan_last;
		logic pend_valid;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/core/trwq_channels.sv
interface trwq_cmd_if;
	import trwq_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [OP_W-1:0]             operation;
	logic [PAYLOAD_W-1:0]        payload;
	logic [TIME_W-1:0]           arrival_stamp;
	logic signed [BOUND_W-1:0]   window_begin;
	logic signed [BOUND_W-1:0]   window_end;

	modport source (
		output valid, operation, payload, arrival_stamp, window_begin, window_end,
		input  ready
	);
	modport sink (
		input  valid, operation, payload, arrival_stamp, window_begin, window_end,
		output ready
	);
endinterface

interface trwq_rsp_if;
	import trwq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [TIME_W-1:0]    out_time;
	logic                 has_data;
	logic [COUNT_W-1:0]   match_number;
	logic [COUNT_W-1:0]   fill_count;
	logic                 last;

	modport source (
		output valid, out_payload, out_time, has_data, match_number, fill_count, last,
		input  ready
	);
	modport sink (
		input  valid, out_payload, out_time, has_data, match_number, fill_count, last,
		output ready
	);
endinterface

### rtl/core/trwq_ctrl.sv
module trwq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            operation,
	output logic                  in_ready,
	input  trwq_pkg::dp_status_t  status,
	output trwq_pkg::ctrl_cmd_t   cmd
);
	import trwq_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SCAN_RD   = 6'b000010,
		ST_SCAN_EV   = 6'b000100,
		ST_LATEST_RD = 6'b001000,
		ST_LATEST_EV = 6'b010000,
		ST_FINISH    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (operation)
						OP_ADD: begin
							cmd.accept_add = 1'b1;
							// The add result looks like an empty marker with the new count.
							if (status.out_free) begin
								cmd.push_marker = 1'b1;
							end else begin
								state_d = ST_FINISH;
							end
						end
						OP_QUERY: begin
							cmd.start_scan = 1'b1;
							state_d = status.held_zero ? ST_FINISH : ST_SCAN_RD;
						end
						OP_LATEST: begin
							cmd.start_latest = 1'b1;
							state_d = status.held_zero ? ST_FINISH : ST_LATEST_RD;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				// A new match can only be held when the previous one can go out,
				// since the last flag is known only when the next match or the end shows.
				if (!status.scan_match || !status.pend_valid || status.out_free) begin
					if (status.scan_match) begin
						cmd.capture   = 1'b1;
						cmd.push_pend = status.pend_valid;
					end
					cmd.advance = 1'b1;
					state_d = status.scan_last ? ST_FINISH : ST_SCAN_RD;
				end
			end
			ST_LATEST_RD: begin
				state_d = ST_LATEST_EV;
			end
			ST_LATEST_EV: begin
				cmd.capture = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					if (status.pend_valid) begin
						cmd.push_pend = 1'b1;
						cmd.push_last = 1'b1;
					end else begin
						cmd.push_marker = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/trwq_datapath.sv
module trwq_datapath #(
	parameter int RING_DEPTH  = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [trwq_pkg::COUNT_W-1:0]           cfg_wr_data,
	input  logic [trwq_pkg::PAYLOAD_W-1:0]         payload,
	input  logic [trwq_pkg::TIME_W-1:0]            arrival_stamp,
	input  logic signed [trwq_pkg::BOUND_W-1:0]    window_begin,
	input  logic signed [trwq_pkg::BOUND_W-1:0]    window_end,
	input  trwq_pkg::ctrl_cmd_t                    cmd,
	output trwq_pkg::dp_status_t                   status,
	trwq_rsp_if.source                             rsp
);
	import trwq_pkg::*;

	localparam int IdxW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CntW   = $clog2(RING_DEPTH + 1);
	localparam int StoreW = (HANDLE_BITS < PAYLOAD_W) ? HANDLE_BITS : PAYLOAD_W;
	localparam int MemW   = TIME_W + StoreW;

	logic [MemW-1:0]     mem [RING_DEPTH];
	logic [MemW-1:0]     rd_data_q;

	logic [CntW-1:0]     len_q;
	logic [CntW-1:0]     len_cfg;
	logic [CntW-1:0]     held_q;
	logic [CntW-1:0]     held_add;
	logic [CntW-1:0]     held_nx;
	logic [IdxW-1:0]     newest_q;
	logic [IdxW-1:0]     newest_add;
	logic [IdxW-1:0]     oldest_q;
	logic [IdxW-1:0]     oldest_add;
	logic [IdxW-1:0]     slot_q;
	logic [CntW-1:0]     idx_q;

	logic [BOUND_W-1:0]  win_begin_q;
	logic [BOUND_W-1:0]  win_end_q;
	logic [TIME_W-1:0]   rd_time;
	logic [StoreW-1:0]   rd_payload;
	logic                above;
	logic                below;

	logic                pend_valid_q;
	logic [StoreW-1:0]   pend_payload_q;
	logic [TIME_W-1:0]   pend_time_q;
	logic [CntW-1:0]     pend_num_q;

	logic                out_valid_q;
	logic [PAYLOAD_W-1:0] out_payload_q;
	logic [TIME_W-1:0]   out_time_q;
	logic                has_data_q;
	logic [COUNT_W-1:0]  match_number_q;
	logic [COUNT_W-1:0]  fill_count_q;
	logic                last_q;
	logic                out_free;
	logic                push;

	function automatic logic [IdxW-1:0] slot_inc(input logic [IdxW-1:0] s,
		input logic [CntW-1:0] len);
		logic [CntW-1:0] nxt;
		nxt = CntW'(s) + CntW'(1);
		return (nxt == len) ? '0 : nxt[IdxW-1:0];
	endfunction

	// Register values outside 1..RING_DEPTH clamp to the nearest end.
	always_comb begin
		if (cfg_wr_data == '0) begin
			len_cfg = CntW'(1);
		end else if (cfg_wr_data > COUNT_W'(RING_DEPTH)) begin
			len_cfg = CntW'(RING_DEPTH);
		end else begin
			len_cfg = cfg_wr_data[CntW-1:0];
		end
	end

	always_comb begin
		held_add   = held_q;
		newest_add = newest_q;
		oldest_add = oldest_q;
		if (held_q == '0) begin
			held_add   = CntW'(1);
			newest_add = '0;
			oldest_add = '0;
		end else if (held_q < len_q) begin
			held_add   = held_q + CntW'(1);
			newest_add = slot_inc(newest_q, len_q);
		end else begin
			newest_add = oldest_q;
			oldest_add = slot_inc(oldest_q, len_q);
		end
	end

	assign held_nx = cmd.accept_add ? held_add : held_q;

	assign rd_time    = rd_data_q[MemW-1:StoreW];
	assign rd_payload = rd_data_q[StoreW-1:0];
	// Stored times are non-negative, so a negative begin always passes and a
	// negative end never does.
	assign above = win_begin_q[BOUND_W-1] || ({1'b0, rd_time} > win_begin_q);
	assign below = !win_end_q[BOUND_W-1] && ({1'b0, rd_time} <= win_end_q);

	assign out_free = !out_valid_q || rsp.ready;
	assign push     = cmd.push_pend || cmd.push_marker;

	assign status.held_zero  = (held_q == '0);
	assign status.scan_match = above && below;
	assign status.scan_last  = ((idx_q + CntW'(1)) == held_q);
	assign status.pend_valid = pend_valid_q;
	assign status.out_free   = out_free;

	always_ff @(posedge clk) begin
		if (cmd.accept_add) begin
			mem[newest_add] <= {arrival_stamp, payload[StoreW-1:0]};
		end
		rd_data_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= CntW'(RING_DEPTH);
			held_q       <= '0;
			newest_q     <= '0;
			oldest_q     <= '0;
			slot_q       <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				len_q    <= len_cfg;
				held_q   <= '0;
				newest_q <= '0;
				oldest_q <= '0;
			end else if (cmd.accept_add) begin
				held_q   <= held_add;
				newest_q <= newest_add;
				oldest_q <= oldest_add;
			end

			if (cmd.start_scan) begin
				slot_q <= oldest_q;
				idx_q  <= '0;
			end else if (cmd.start_latest) begin
				slot_q <= newest_q;
			end else if (cmd.advance) begin
				slot_q <= slot_inc(slot_q, len_q);
				idx_q  <= idx_q + CntW'(1);
			end

			if (cmd.accept_add || cmd.start_scan || cmd.start_latest) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.capture) begin
				pend_valid_q <= 1'b1;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_scan) begin
			win_begin_q <= window_begin;
			win_end_q   <= window_end;
		end
		if (cmd.capture) begin
			pend_payload_q <= rd_payload;
			pend_time_q    <= rd_time;
			pend_num_q     <= pend_valid_q ? (pend_num_q + CntW'(1)) : CntW'(1);
		end
		if (cmd.push_pend) begin
			out_payload_q  <= PAYLOAD_W'(pend_payload_q);
			out_time_q     <= pend_time_q;
			has_data_q     <= 1'b1;
			match_number_q <= COUNT_W'(pend_num_q);
			fill_count_q   <= COUNT_W'(held_nx);
			last_q         <= cmd.push_last;
		end else if (cmd.push_marker) begin
			out_payload_q  <= '0;
			out_time_q     <= '0;
			has_data_q     <= 1'b0;
			match_number_q <= '0;
			fill_count_q   <= COUNT_W'(held_nx);
			last_q         <= 1'b1;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.out_payload  = out_payload_q;
	assign rsp.out_time     = out_time_q;
	assign rsp.has_data     = has_data_q;
	assign rsp.match_number = match_number_q;
	assign rsp.fill_count   = fill_count_q;
	assign rsp.last         = last_q;

endmodule

### rtl/core/timestamped_ring_with_window_query.sv
// Ring of timestamped message handles with time-window readout.
// Items arrive on cmd (valid/ready): an add stores payload and arrival_stamp,
// overwriting the oldest entry once ring_length entries are held; a window
// query returns every held entry with window_begin < time <= window_end, oldest
// first; a latest query returns the newest entry. Results leave on rsp
// (valid/ready) from an output register; last marks the final result of an
// item, and a result with has_data low is an empty marker.
// An add is taken in IDLE; its result is registered at the same edge that takes
// the item, or in FINISH if rsp stalls. A latest query reads, then checks the
// newest entry; a window query reads and checks each held entry in turn, since
// the single read port of the entry memory is read once and compared once per
// entry; both close in FINISH. cmd is ready again once an item's last result is
// registered; adds can follow each other on every cycle while rsp is free.
// When rsp stalls, the result register holds its item; an add is still taken
// and its result waits, while a scan pauses on its next match.
// Reset empties the ring and sets ring_length to its largest value; writing
// cfg_wr_data with cfg_wr_en high also empties the ring.
module timestamped_ring_with_window_query #(
	parameter int RING_DEPTH  = 64,
	parameter int HANDLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [trwq_pkg::COUNT_W-1:0]  cfg_wr_data,
	trwq_cmd_if.sink                      cmd,
	trwq_rsp_if.source                    rsp
);
	import trwq_pkg::*;

	ctrl_cmd_t  ctrl_cmd;
	dp_status_t dp_status;
	logic       in_ready;

	assign cmd.ready = in_ready;

	trwq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.operation (cmd.operation),
		.in_ready  (in_ready),
		.status    (dp_status),
		.cmd       (ctrl_cmd)
	);

	trwq_datapath #(
		.RING_DEPTH  (RING_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.payload       (cmd.payload),
		.arrival_stamp (cmd.arrival_stamp),
		.window_begin  (cmd.window_begin),
		.window_end    (cmd.window_end),
		.cmd           (ctrl_cmd),
		.status        (dp_status),
		.rsp           (rsp)
	);

endmodule

### rtl/core/trwq_checker.sv
`include "timestamped_ring_with_window_query_macros.svh"

module trwq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  operation,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] out_payload,
	input logic [62:0] out_time,
	input logic        has_data,
	input logic [6:0]  match_number,
	input logic [6:0]  fill_count,
	input logic        last
);
	import trwq_pkg::*;

	// An empty marker or add result carries no entry and closes its item.
	`TRWQ_ASSERT(a_marker_clean, rsp_valid && !has_data, out_payload == 32'd0 && out_time == 63'd0 && match_number == 7'd0 && last, "empty result carries entry fields")
	// A returned entry is numbered within the entries the ring holds.
	`TRWQ_ASSERT(a_match_in_range, rsp_valid && has_data, match_number != 7'd0 && match_number <= fill_count, "match number out of range")
	`TRWQ_ASSERT(a_fill_bound, rsp_valid, fill_count <= 7'd64, "fill count beyond ring size")
	// A window query always keeps the block busy once it is taken.
	`TRWQ_ASSERT_NEXT(a_query_busy, cmd_valid && cmd_ready && operation == OP_QUERY, !cmd_ready, "item taken during a window query")
	`TRWQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_payload) && $stable(match_number) && $stable(last), "stalled result changed")

endmodule

bind timestamped_ring_with_window_query trwq_checker u_trwq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.operation    (cmd.operation),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.out_payload  (rsp.out_payload),
	.out_time     (rsp.out_time),
	.has_data     (rsp.has_data),
	.match_number (rsp.match_number),
	.fill_count   (rsp.fill_count),
	.last         (rsp.last)
);
